// ===== sv/pdb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdb_pkg
// Shared types, mode codes and operand-forming functions for the
// Porter-Duff pixel blender.
// ----------------------------------------------------------------------------
package pdb_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned NumCh  = 4;
  localparam int unsigned PixelW = ChanW * NumCh;
  localparam int unsigned ModeW  = 4;

  typedef logic [ChanW-1:0]  chan_t;
  typedef logic [PixelW-1:0] pixel_t;

  // compositing modes
  typedef enum logic [ModeW-1:0] {
    MODE_CLEAR   = 4'd0,
    MODE_SRC     = 4'd1,
    MODE_DST     = 4'd2,
    MODE_SRCOVER = 4'd3,
    MODE_DSTOVER = 4'd4,
    MODE_SRCIN   = 4'd5,
    MODE_DSTIN   = 4'd6,
    MODE_SRCOUT  = 4'd7,
    MODE_DSTOUT  = 4'd8,
    MODE_SRCATOP = 4'd9,
    MODE_DSTATOP = 4'd10,
    MODE_XOR     = 4'd11
  } mode_t;

  localparam mode_t ModeReset = MODE_SRCOVER;

  // per channel: result = sat8(a + div255(m1*x + m2*y))
  typedef struct packed {
    chan_t x;
    chan_t y;
    chan_t a;
  } lane_op_t;

  typedef struct packed {
    chan_t              m1;
    chan_t              m2;
    lane_op_t [NumCh-1:0] lane;  // lane 3 is alpha
  } blend_op_t;

  // stage load enables for the channel lanes
  typedef struct packed {
    logic en2;
    logic en3;
    logic en4;
  } lane_ctrl_t;

  function automatic chan_t alpha_of(pixel_t p);
    return p[PixelW-1 -: ChanW];
  endfunction

  // plain pass of a pixel (all factors zero)
  function automatic blend_op_t op_pass(pixel_t p);
    blend_op_t o;
    o = '0;
    for (int k = 0; k < NumCh; k++) o.lane[k].a = p[ChanW*k +: ChanW];
    return o;
  endfunction

  // every channel of p scaled by f/255
  function automatic blend_op_t op_scale(pixel_t p, chan_t f);
    blend_op_t o;
    o = '0;
    o.m1 = f;
    for (int k = 0; k < NumCh; k++) o.lane[k].x = p[ChanW*k +: ChanW];
    return o;
  endfunction

  // p + q*(255-pa)/255, also serves p + out(q,p)
  function automatic blend_op_t op_over(pixel_t p, pixel_t q);
    blend_op_t o;
    o = '0;
    o.m1 = ~alpha_of(p);
    for (int k = 0; k < NumCh; k++) begin
      o.lane[k].a = p[ChanW*k +: ChanW];
      o.lane[k].x = q[ChanW*k +: ChanW];
    end
    return o;
  endfunction

  // full atop: (qa*p + (255-pa)*q)/255
  function automatic blend_op_t op_atop(pixel_t p, pixel_t q);
    blend_op_t o;
    o = '0;
    o.m1 = alpha_of(q);
    o.m2 = ~alpha_of(p);
    for (int k = 0; k < NumCh; k++) begin
      o.lane[k].x = p[ChanW*k +: ChanW];
      o.lane[k].y = q[ChanW*k +: ChanW];
    end
    return o;
  endfunction

  // atop mode with its shortcuts
  function automatic blend_op_t op_atop_mode(pixel_t p, pixel_t q);
    chan_t pa;
    chan_t qa;
    blend_op_t o;
    pa = alpha_of(p);
    qa = alpha_of(q);
    if (pa == 8'd0)        o = op_pass(q);
    else if (qa == 8'd0)   o = '0;
    else if (qa == 8'hff)  o = (pa == 8'hff) ? op_pass(p) : op_over(p, q);
    else if (pa == 8'hff)  o = op_scale(p, qa);
    else                   o = op_atop(p, q);
    return o;
  endfunction

  // (255-sa)*d + (255-da)*s
  function automatic blend_op_t xor_terms(pixel_t s, pixel_t d);
    blend_op_t o;
    o = '0;
    o.m1 = ~alpha_of(s);
    o.m2 = ~alpha_of(d);
    for (int k = 0; k < NumCh; k++) begin
      o.lane[k].x = d[ChanW*k +: ChanW];
      o.lane[k].y = s[ChanW*k +: ChanW];
    end
    return o;
  endfunction

endpackage

// ===== sv/pdb_ifs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdb_ifs
// Valid/ready channels for pixel pairs going in and blended pixels coming out.
// ----------------------------------------------------------------------------
interface pdb_in_if;
  logic             valid;
  logic             ready;
  pdb_pkg::pixel_t  src_pixel;
  pdb_pkg::pixel_t  dst_pixel;

  modport source (output valid, output src_pixel, output dst_pixel, input ready);
  modport sink   (input valid, input src_pixel, input dst_pixel, output ready);
endinterface

interface pdb_out_if;
  logic             valid;
  logic             ready;
  pdb_pkg::pixel_t  out_pixel;

  modport source (output valid, output out_pixel, input ready);
  modport sink   (input valid, input out_pixel, output ready);
endinterface

// ===== sv/pdb_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdb_decode
// Turns mode, source and destination into multiply-add operands, taking the
// alpha 0 / alpha 255 shortcuts of each mode that has them.
// ----------------------------------------------------------------------------
module pdb_decode (
  input  pdb_pkg::mode_t     mode,
  input  pdb_pkg::pixel_t    src,
  input  pdb_pkg::pixel_t    dst,
  output pdb_pkg::blend_op_t op
);
  import pdb_pkg::*;

  chan_t sa;
  chan_t da;

  assign sa = alpha_of(src);
  assign da = alpha_of(dst);

  // per-mode operand selection
  always_comb begin
    op = '0;
    case (mode)
      MODE_CLEAR: op = '0;
      MODE_SRC:   op = op_pass(src);
      MODE_DST:   op = op_pass(dst);
      MODE_SRCOVER: begin
        if (da == 8'd0 || sa == 8'hff) op = op_pass(src);
        else if (sa == 8'd0)           op = op_pass(dst);
        else                           op = op_over(src, dst);
      end
      MODE_DSTOVER: begin
        if (sa == 8'd0 || da == 8'hff) op = op_pass(dst);
        else if (da == 8'd0)           op = op_pass(src);
        else                           op = op_over(dst, src);
      end
      MODE_SRCIN: begin
        if (da == 8'd0 || sa == 8'd0)  op = '0;
        else if (da == 8'hff)          op = op_pass(src);
        else                           op = op_scale(src, da);
      end
      MODE_DSTIN: begin
        if (sa == 8'd0 || da == 8'd0)  op = '0;
        else if (sa == 8'hff)          op = op_pass(dst);
        else                           op = op_scale(dst, sa);
      end
      MODE_SRCOUT: begin
        if (da == 8'hff || sa == 8'd0) op = '0;
        else if (da == 8'd0)           op = op_pass(src);
        else                           op = op_scale(src, ~da);
      end
      MODE_DSTOUT: begin
        if (sa == 8'hff || da == 8'd0) op = '0;
        else if (sa == 8'd0)           op = op_pass(dst);
        else                           op = op_scale(dst, ~sa);
      end
      MODE_SRCATOP: op = op_atop_mode(src, dst);
      MODE_DSTATOP: op = op_atop_mode(dst, src);
      MODE_XOR: begin
        if (da == 8'd0)       op = (sa == 8'd0) ? '0 : op_pass(src);
        else if (sa == 8'd0)  op = op_pass(dst);
        else if (da == 8'hff) op = (sa == 8'hff) ? '0 : op_scale(dst, ~sa);
        else if (sa == 8'hff) op = op_scale(src, ~da);
        else                  op = xor_terms(src, dst);
      end
      default: op = op_pass(dst);
    endcase
  end

endmodule

// ===== sv/pdb_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdb_lane
// One colour channel: multiply, rounded divide by 255, add and saturate,
// over three register stages.
// ----------------------------------------------------------------------------
module pdb_lane (
  input  logic                clk,
  input  pdb_pkg::lane_ctrl_t ctrl,
  input  pdb_pkg::chan_t      m1,
  input  pdb_pkg::chan_t      m2,
  input  pdb_pkg::lane_op_t   op,
  output pdb_pkg::chan_t      res
);
  import pdb_pkg::*;

  localparam int unsigned ProdW = 2 * ChanW;
  localparam int unsigned SumW  = ProdW + 1;
  localparam int unsigned MulW  = SumW + 9;
  localparam int unsigned QuotW = MulW - ProdW;

  logic [ProdW-1:0] p1_r, p1_nxt;
  logic [ProdW-1:0] p2_r, p2_nxt;
  chan_t            a2_r;
  logic [QuotW-1:0] t_r, t_nxt;
  chan_t            a3_r;
  chan_t            res_r, res_nxt;

  logic [SumW-1:0]  sum;
  logic [MulW-1:0]  mul257;
  logic [QuotW:0]   total;

  // stage 2: the two products
  assign p1_nxt = m1 * op.x;
  assign p2_nxt = m2 * op.y;

  // stage 3: (v + 128) * 257 >> 16
  assign sum    = SumW'(p1_r) + SumW'(p2_r) + SumW'(128);
  assign mul257 = MulW'(sum) + (MulW'(sum) << 8);
  assign t_nxt  = mul257[MulW-1 -: QuotW];

  // stage 4: add the pass term and saturate
  assign total   = (QuotW+1)'(a3_r) + (QuotW+1)'(t_r);
  assign res_nxt = (total > (QuotW+1)'(255)) ? 8'hff : total[ChanW-1:0];

  always_ff @(posedge clk) begin
    if (ctrl.en2) begin
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      a2_r <= op.a;
    end
    if (ctrl.en3) begin
      t_r  <= t_nxt;
      a3_r <= a2_r;
    end
    if (ctrl.en4) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== sv/porter_duff_pixel_blend.sv =====
`timescale 1ns / 1ps
// An accepted word passes the operand, product, quotient and result registers
// on its way to out_ch. One pixel per cycle while out_ch is ready; the four
// stages are decode, multiply, divide-by-255 and add/saturate, each with its own valid bit.
// A stalled output holds its stage; empty stages ahead still fill.
// Reset (rst_n low, synchronous) empties the pipeline and sets the mode
// register to src-over.
// ----------------------------------------------------------------------------
// porter_duff_pixel_blend
// Porter-Duff compositing of premultiplied ARGB8888 pixels, twelve modes.
// ----------------------------------------------------------------------------
module porter_duff_pixel_blend (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [pdb_pkg::ModeW-1:0] cfg_wdata,
  pdb_in_if.sink              in_ch,
  pdb_out_if.source           out_ch
);
  import pdb_pkg::*;

  mode_t      mode_r;
  blend_op_t  op_nxt;
  blend_op_t  op_r;
  logic       v1_r, v2_r, v3_r, v4_r;
  logic       rdy1, rdy2, rdy3, rdy4;
  lane_ctrl_t lane_ctrl;
  chan_t [NumCh-1:0] res;

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ModeReset;
    end else if (cfg_we) begin
      mode_r <= mode_t'(cfg_wdata);
    end
  end

  // stage readiness, collapsing bubbles
  assign rdy4 = !v4_r || out_ch.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: decode into operands
  pdb_decode u_decode (
    .mode (mode_r),
    .src  (in_ch.src_pixel),
    .dst  (in_ch.dst_pixel),
    .op   (op_nxt)
  );

  always_ff @(posedge clk) begin
    if (rdy1) op_r <= op_nxt;
  end

  assign lane_ctrl.en2 = rdy2;
  assign lane_ctrl.en3 = rdy3;
  assign lane_ctrl.en4 = rdy4;

  // stages 2 to 4: one lane per channel
  for (genvar k = 0; k < NumCh; k++) begin : g_lane
    pdb_lane u_lane (
      .clk  (clk),
      .ctrl (lane_ctrl),
      .m1   (op_r.m1),
      .m2   (op_r.m2),
      .op   (op_r.lane[k]),
      .res  (res[k])
    );
  end

  assign out_ch.valid     = v4_r;
  assign out_ch.out_pixel = res;

endmodule

// ===== sv/pdb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdb_checker
// Port-level checks on the pixel blender, bound to the top level.
// ----------------------------------------------------------------------------
module pdb_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input pdb_pkg::pixel_t out_pixel
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its pixel
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel))
    else $error("result pixel changed while stalled");

  // pipeline is empty straight after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_valid)
    else $error("result offered straight after reset");

  // an accepted word reaches the output when the output keeps taking
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("word did not reach the output in four cycles");

endmodule

bind porter_duff_pixel_blend pdb_checker u_pdb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_pixel (out_ch.out_pixel)
);
